/* hdl/srp_pkg.sv */
// srp_pkg: shared types and constants of the sign random projection hash core
// payload structs, sequencer states, multiply-accumulate tags, register and command codes
// no dependencies
`timescale 1ns / 1ps

package srp_pkg;

	// fixed arithmetic widths
	localparam int VALUE_BITS = 16;
	localparam int PROD_W     = 2 * VALUE_BITS;
	localparam int ACC_W      = 48;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 9;
	localparam logic [CFG_IDX_W-1:0] CFG_DIMS  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BYTES = 1'd1;
	localparam logic [8:0] DIMS_RESET  = 9'd256;
	localparam logic [3:0] BYTES_RESET = 4'd8;

	// request commands
	localparam logic CMD_WEIGHT = 1'b0;
	localparam logic CMD_EMBED  = 1'b1;

	typedef struct packed {
		logic                         cmd;
		logic [5:0]                   plane;
		logic [7:0]                   dim;
		logic signed [VALUE_BITS-1:0] value;
		logic                         last;
	} srp_in_t;

	typedef struct packed {
		logic [7:0] hash_byte;
		logic [2:0] byte_index;
		logic       last_byte;
	} srp_out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_WAIT,
		ST_PUSH
	} srp_state_t;

	// tag that travels with each product through the shared unit
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} mac_tag_t;

	// sign of one finished dot product
	typedef struct packed {
		logic valid;
		logic sign_bit;
	} mac_res_t;

endpackage

/* hdl/sign_random_projection_hash_core.sv */
// Sign random projection hash core: top level
// Channels: item (valid/ready request of srp_in_t) carries weight writes (cmd 0) and
// embedding writes (cmd 1); an embedding write with last set starts a hash run.
// result (valid/ready of srp_out_t) returns the hash one byte per transfer, byte_index
// counting from 0 and last_byte on the final byte; the first plane sits in bit 7.
// Configuration: cfg_we/cfg_index/cfg_data write dims_in_use (0) and bytes_in_use (1).
// The user must write them only while the core is idle; the core does not enforce it.
// Run: a hash run is carried out by the single multiply-accumulate unit, which
// handles one product per cycle within a plane; each product passes a memory read
// and a product stage before it is accumulated. item_ready is low during a run.
// Stall: a finished byte waits in the result register; while it is not taken the
// sequencer holds before loading the next byte. Requests are taken again as soon as
// the run's last byte sits in the result register.
// Reset: arst_n clears control state and restores dims_in_use 256, bytes_in_use 8;
// weight and embedding memories are not cleared and must be written before use.
// Dependencies: srp_pkg, srp_store, srp_mac, srp_ctrl
`timescale 1ns / 1ps

module sign_random_projection_hash_core import srp_pkg::*; #(
	parameter int MAX_DIMS  = 256,
	parameter int MAX_BYTES = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  srp_in_t               item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output srp_out_t              result
);

	localparam int DIM_W   = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int BYTE_W  = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
	localparam int WADDR_W = $clog2(8 * MAX_BYTES * MAX_DIMS);

	logic                  w_we;
	logic [WADDR_W-1:0]    w_waddr;
	logic                  e_we;
	logic [DIM_W-1:0]      e_waddr;
	logic [VALUE_BITS-1:0] wdata;
	logic [WADDR_W-1:0]    w_raddr;
	logic [DIM_W-1:0]      e_raddr;
	logic [VALUE_BITS-1:0] w_rdata;
	logic [VALUE_BITS-1:0] e_rdata;
	mac_tag_t              issue;
	mac_res_t              res;

	// sequencer and registers
	srp_ctrl #(
		.MAX_DIMS  (MAX_DIMS),
		.MAX_BYTES (MAX_BYTES),
		.WADDR_W   (WADDR_W),
		.DIM_W     (DIM_W),
		.BYTE_W    (BYTE_W)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.w_we         (w_we),
		.w_waddr      (w_waddr),
		.e_we         (e_we),
		.e_waddr      (e_waddr),
		.wdata        (wdata),
		.w_raddr      (w_raddr),
		.e_raddr      (e_raddr),
		.issue        (issue),
		.res          (res)
	);

	// weight and embedding memories
	srp_store #(
		.WADDR_W (WADDR_W),
		.DIM_W   (DIM_W)
	) u_store (
		.clk     (clk),
		.w_we    (w_we),
		.w_waddr (w_waddr),
		.e_we    (e_we),
		.e_waddr (e_waddr),
		.wdata   (wdata),
		.w_raddr (w_raddr),
		.e_raddr (e_raddr),
		.w_rdata (w_rdata),
		.e_rdata (e_rdata)
	);

	// shared multiply-accumulate
	srp_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.issue   (issue),
		.w_rdata (w_rdata),
		.e_rdata (e_rdata),
		.res     (res)
	);

	// no product issued while requests are open
	a_issue_busy: assert property (@(posedge clk) disable iff (!arst_n)
		issue.valid |-> !item_ready)
		else $error("product issued while idle");

	// plane result only arrives during a run
	a_res_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !item_ready)
		else $error("plane result outside a hash run");

	// a request with last on an embedding starts a run
	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && item_ready && item.cmd == CMD_EMBED && item.last) |=> !item_ready)
		else $error("hash run did not start");

endmodule

/* hdl/srp_store.sv */
// srp_store: weight table and embedding buffer memories
// one write port and one registered read port each; uses srp_pkg
`timescale 1ns / 1ps

module srp_store import srp_pkg::*; #(
	parameter int WADDR_W = 14,
	parameter int DIM_W   = 8
) (
	input  logic                  clk,
	input  logic                  w_we,
	input  logic [WADDR_W-1:0]    w_waddr,
	input  logic                  e_we,
	input  logic [DIM_W-1:0]      e_waddr,
	input  logic [VALUE_BITS-1:0] wdata,
	input  logic [WADDR_W-1:0]    w_raddr,
	input  logic [DIM_W-1:0]      e_raddr,
	output logic [VALUE_BITS-1:0] w_rdata,
	output logic [VALUE_BITS-1:0] e_rdata
);

	logic [VALUE_BITS-1:0] weight_mem [2**WADDR_W];
	logic [VALUE_BITS-1:0] embed_mem  [2**DIM_W];

	// weight table
	always_ff @(posedge clk) begin
		if (w_we) begin
			weight_mem[w_waddr] <= wdata;
		end
		w_rdata <= weight_mem[w_raddr];
	end

	// embedding buffer
	always_ff @(posedge clk) begin
		if (e_we) begin
			embed_mem[e_waddr] <= wdata;
		end
		e_rdata <= embed_mem[e_raddr];
	end

endmodule

/* hdl/srp_mac.sv */
// srp_mac: shared multiply-accumulate unit with sign decision
// tag aligned to registered memory data, product stage, 48-bit accumulator; uses srp_pkg
`timescale 1ns / 1ps

module srp_mac import srp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mac_tag_t              issue,
	input  logic [VALUE_BITS-1:0] w_rdata,
	input  logic [VALUE_BITS-1:0] e_rdata,
	output mac_res_t              res
);

	mac_tag_t                 tag_s1;
	mac_tag_t                 tag_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic signed [ACC_W-1:0]  acc_next;
	mac_res_t                 res_q;

	// tags follow the memory read latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1 <= issue;
			tag_s2 <= tag_s1;
		end
	end

	// product stage
	always_ff @(posedge clk) begin
		prod_s2 <= $signed(w_rdata) * $signed(e_rdata);
	end

	// accumulate, restart on the first dimension of a plane
	always_comb begin
		if (tag_s2.first) begin
			acc_next = ACC_W'(prod_s2);
		end else begin
			acc_next = acc_q + ACC_W'(prod_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			res_q <= '0;
		end else begin
			if (tag_s2.valid) begin
				acc_q <= acc_next;
			end
			res_q.valid    <= tag_s2.valid && tag_s2.last;
			res_q.sign_bit <= (acc_next != '0) && !acc_next[ACC_W-1];
		end
	end

	assign res = res_q;

endmodule

/* hdl/srp_ctrl.sv */
// srp_ctrl: configuration registers, request decode, hash sequencer and result register
// drives srp_store addresses and srp_mac tags; uses srp_pkg
`timescale 1ns / 1ps

module srp_ctrl import srp_pkg::*; #(
	parameter int MAX_DIMS  = 256,
	parameter int MAX_BYTES = 8,
	parameter int WADDR_W   = 14,
	parameter int DIM_W     = 8,
	parameter int BYTE_W    = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  srp_in_t               item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output srp_out_t              result,
	output logic                  w_we,
	output logic [WADDR_W-1:0]    w_waddr,
	output logic                  e_we,
	output logic [DIM_W-1:0]      e_waddr,
	output logic [VALUE_BITS-1:0] wdata,
	output logic [WADDR_W-1:0]    w_raddr,
	output logic [DIM_W-1:0]      e_raddr,
	output mac_tag_t              issue,
	input  mac_res_t              res
);

	localparam int PLANES = 8 * MAX_BYTES;

	logic [8:0]         dims_q;
	logic [3:0]         bytes_q;
	srp_state_t         state_q, state_d;
	logic [DIM_W-1:0]   d_q, d_d;
	logic [2:0]         j_q, j_d;
	logic [BYTE_W-1:0]  b_q, b_d;
	logic [WADDR_W-1:0] base_q, base_d;
	logic [7:0]         coll_q, coll_d;
	logic               out_valid_q;
	srp_out_t           out_q;
	logic               accept;
	logic               out_free;
	logic               out_load;
	logic [31:0]        k_eff, nb_eff;
	logic [DIM_W-1:0]   dim_last;
	logic [BYTE_W-1:0]  byte_last;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q  <= DIMS_RESET;
			bytes_q <= BYTES_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DIMS:  dims_q  <= cfg_data;
				CFG_BYTES: bytes_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// clamp registers to the supported range
	always_comb begin
		if (dims_q == '0) begin
			k_eff = 32'd1;
		end else if (32'(dims_q) > 32'(MAX_DIMS)) begin
			k_eff = 32'(MAX_DIMS);
		end else begin
			k_eff = 32'(dims_q);
		end
		if (bytes_q == '0) begin
			nb_eff = 32'd1;
		end else if (32'(bytes_q) > 32'(MAX_BYTES)) begin
			nb_eff = 32'(MAX_BYTES);
		end else begin
			nb_eff = 32'(bytes_q);
		end
		dim_last  = DIM_W'(k_eff - 32'd1);
		byte_last = BYTE_W'(nb_eff - 32'd1);
	end

	// request decode and memory writes
	assign item_ready = (state_q == ST_IDLE);
	assign accept     = item_valid && item_ready;
	assign w_we       = accept && (item.cmd == CMD_WEIGHT) &&
	                    (32'(item.plane) < 32'(PLANES)) && (32'(item.dim) < 32'(MAX_DIMS));
	assign w_waddr    = WADDR_W'(32'(item.plane) * 32'(MAX_DIMS) + 32'(item.dim));
	assign e_we       = accept && (item.cmd == CMD_EMBED) && (32'(item.dim) < 32'(MAX_DIMS));
	assign e_waddr    = DIM_W'(item.dim);
	assign wdata      = item.value;

	// read addresses and tags toward the shared unit
	assign w_raddr     = base_q + WADDR_W'(d_q);
	assign e_raddr     = d_q;
	assign issue.valid = (state_q == ST_ISSUE);
	assign issue.first = (d_q == '0);
	assign issue.last  = (d_q == dim_last);

	assign out_free = !out_valid_q || result_ready;

	// sequencer: one plane per pass, one result per eight planes
	always_comb begin
		state_d  = state_q;
		d_d      = d_q;
		j_d      = j_q;
		b_d      = b_q;
		base_d   = base_q;
		coll_d   = coll_q;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && (item.cmd == CMD_EMBED) && item.last) begin
					d_d     = '0;
					j_d     = '0;
					b_d     = '0;
					base_d  = '0;
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				if (d_q == dim_last) begin
					state_d = ST_WAIT;
				end else begin
					d_d = d_q + 1'b1;
				end
			end
			ST_WAIT: begin
				if (res.valid) begin
					coll_d = {coll_q[6:0], res.sign_bit};
					if (j_q == 3'd7) begin
						state_d = ST_PUSH;
					end else begin
						j_d     = j_q + 1'b1;
						d_d     = '0;
						base_d  = base_q + WADDR_W'(MAX_DIMS);
						state_d = ST_ISSUE;
					end
				end
			end
			ST_PUSH: begin
				if (out_free) begin
					out_load = 1'b1;
					j_d      = '0;
					d_d      = '0;
					base_d   = base_q + WADDR_W'(MAX_DIMS);
					if (b_q == byte_last) begin
						state_d = ST_IDLE;
					end else begin
						b_d     = b_q + 1'b1;
						state_d = ST_ISSUE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			d_q     <= '0;
			j_q     <= '0;
			b_q     <= '0;
			base_q  <= '0;
			coll_q  <= '0;
		end else begin
			state_q <= state_d;
			d_q     <= d_d;
			j_q     <= j_d;
			b_q     <= b_d;
			base_q  <= base_d;
			coll_q  <= coll_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.hash_byte  <= coll_q;
			out_q.byte_index <= 3'(b_q);
			out_q.last_byte  <= (b_q == byte_last);
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule
